@@ rtl/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg
// Types and constants shared by the ray versus box slab test block.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int AXES         = 3;
   localparam int PACKED_LANES = 4;
   localparam int COORD_W      = 16;
   localparam int INV_W        = 32;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = DIFF_W + INV_W;
   localparam int STAGES       = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [INV_W-1:0]   inv_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  dist_type;

   typedef logic [PACKED_LANES*COORD_W-1:0] lanes_type;
   typedef logic [PACKED_LANES-1:0]         mask_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } ctrl_type;

endpackage

@@ rtl/rbst_req_if.sv @@
// ----------------------------------------------------------------------------
// rbst_req_if
// Request channel: one ray and four packed boxes per transfer.
// ----------------------------------------------------------------------------
interface rbst_req_if
   import rbst_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type origin_x;
   coord_type origin_y;
   coord_type origin_z;
   inv_type   inv_dir_x;
   inv_type   inv_dir_y;
   inv_type   inv_dir_z;
   lanes_type box_lo_x_lanes;
   lanes_type box_lo_y_lanes;
   lanes_type box_lo_z_lanes;
   lanes_type box_hi_x_lanes;
   lanes_type box_hi_y_lanes;
   lanes_type box_hi_z_lanes;

   modport source (
      output valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
      output box_lo_x_lanes, box_lo_y_lanes, box_lo_z_lanes,
      output box_hi_x_lanes, box_hi_y_lanes, box_hi_z_lanes,
      input  ready
   );

   modport sink (
      input  valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
      input  box_lo_x_lanes, box_lo_y_lanes, box_lo_z_lanes,
      input  box_hi_x_lanes, box_hi_y_lanes, box_hi_z_lanes,
      output ready
   );
endinterface

@@ rtl/rbst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rbst_rsp_if
// Response channel: one hit mask per transfer.
// ----------------------------------------------------------------------------
interface rbst_rsp_if
   import rbst_pkg::*;
   ();
   logic     valid;
   logic     ready;
   mask_type hit_mask;

   modport source (output valid, hit_mask, input ready);
   modport sink (input valid, hit_mask, output ready);
endinterface

@@ rtl/rbst_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbst_ctrl
// Stage valid bits and load enables for the lane pipeline.
// ----------------------------------------------------------------------------
module rbst_ctrl
   import rbst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign ctrl.load = load;

endmodule

@@ rtl/rbst_lane.sv @@
// ----------------------------------------------------------------------------
// rbst_lane
// One lane of the slab test: slab distances, entry and exit, hit decision.
// ----------------------------------------------------------------------------
module rbst_lane
   import rbst_pkg::*;
(
   input  logic                 clock,
   input  ctrl_type             ctrl,
   input  coord_type [AXES-1:0] origin,
   input  inv_type   [AXES-1:0] inv_dir,
   input  coord_type [AXES-1:0] box_lo,
   input  coord_type [AXES-1:0] box_hi,
   output logic                 hit
);

   diff_type [AXES-1:0] dlo_ff, dlo_in, dhi_ff, dhi_in;
   inv_type  [AXES-1:0] inv_ff;
   dist_type [AXES-1:0] tlo_ff, tlo_in, thi_ff, thi_in;
   dist_type [AXES-1:0] near_ff, near_in, far_ff, far_in;
   dist_type            entry_ff, entry_in, exit_ff, exit_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         dlo_in[a] = DIFF_W'(box_lo[a]) - DIFF_W'(origin[a]);
         dhi_in[a] = DIFF_W'(box_hi[a]) - DIFF_W'(origin[a]);
         tlo_in[a] = PROD_W'(dlo_ff[a]) * PROD_W'(inv_ff[a]);
         thi_in[a] = PROD_W'(dhi_ff[a]) * PROD_W'(inv_ff[a]);
         near_in[a] = (tlo_ff[a] < thi_ff[a]) ? tlo_ff[a] : thi_ff[a];
         far_in[a]  = (tlo_ff[a] > thi_ff[a]) ? tlo_ff[a] : thi_ff[a];
      end
   end

   always_comb begin
      entry_in = near_ff[0];
      exit_in  = far_ff[0];
      for (int a = 1; a < AXES; a++) begin
         if (near_ff[a] > entry_in) begin
            entry_in = near_ff[a];
         end
         if (far_ff[a] < exit_in) begin
            exit_in = far_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         dlo_ff <= dlo_in;
         dhi_ff <= dhi_in;
         inv_ff <= inv_dir;
      end
      if (ctrl.load[1]) begin
         tlo_ff <= tlo_in;
         thi_ff <= thi_in;
      end
      if (ctrl.load[2]) begin
         near_ff <= near_in;
         far_ff  <= far_in;
      end
      if (ctrl.load[3]) begin
         entry_ff <= entry_in;
         exit_ff  <= exit_in;
      end
   end

   // The box is hit when the exit distance is not behind the origin
   // and not before the entry distance.
   assign hit = (exit_ff >= entry_ff) && !exit_ff[PROD_W-1];

endmodule

@@ rtl/rbst_merge.sv @@
// ----------------------------------------------------------------------------
// rbst_merge
// Collects the lane decisions into the registered hit mask.
// ----------------------------------------------------------------------------
module rbst_merge
   import rbst_pkg::*;
(
   input  logic     clock,
   input  ctrl_type ctrl,
   input  mask_type lane_hit,
   output mask_type hit_mask
);

   mask_type mask_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[STAGES-1]) begin
         mask_ff <= lane_hit;
      end
   end

   assign hit_mask = mask_ff;

endmodule

@@ rtl/ray_box_slab_test_four_lane.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test_four_lane
// Tests one ray against up to four axis-aligned boxes by the slab method.
// ----------------------------------------------------------------------------
// Each transfer on req_ch carries a ray origin (Q8.8), its reciprocal
// direction (Q16.16) and four boxes packed lane by lane. Each transfer on
// rsp_ch returns a four-bit mask with bit i set when the ray hits box i.
// The lanes work side by side in a five-stage pipeline: edge minus origin,
// the exact 17 by 32 bit products, slab near and far, entry and exit, and
// the hit mask register. One request is taken every cycle unless the
// receiver stalls with the pipeline full, so the rate is one item per
// cycle. The multipliers set the stage depth.
// Each stage holds its item until the next stage has room, so empty stages
// close up and requests keep flowing while a result waits. When the
// receiver stalls with the pipeline full, req_ch.ready drops.
// Synchronous reset empties the pipeline; no result is pending after it.
// LANES sets how many lanes are built; only the lanes below both LANES and
// four are tested, and mask bits of lanes not built read zero.
// ----------------------------------------------------------------------------
module ray_box_slab_test_four_lane
   import rbst_pkg::*;
#(
   parameter int LANES = 4
)
(
   input logic        clock,
   input logic        reset,
   rbst_req_if.sink   req_ch,
   rbst_rsp_if.source rsp_ch
);

   localparam int TESTED = (LANES < PACKED_LANES) ? LANES : PACKED_LANES;

   ctrl_type             ctrl;
   mask_type             lane_hit;
   coord_type [AXES-1:0] origin;
   inv_type   [AXES-1:0] inv_dir;

   assign origin  = {req_ch.origin_z, req_ch.origin_y, req_ch.origin_x};
   assign inv_dir = {req_ch.inv_dir_z, req_ch.inv_dir_y, req_ch.inv_dir_x};

   rbst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   for (genvar i = 0; i < PACKED_LANES; i++) begin : g_lane
      if (i < TESTED) begin : g_on
         coord_type [AXES-1:0] box_lo;
         coord_type [AXES-1:0] box_hi;

         assign box_lo = {req_ch.box_lo_z_lanes[i*COORD_W +: COORD_W],
                          req_ch.box_lo_y_lanes[i*COORD_W +: COORD_W],
                          req_ch.box_lo_x_lanes[i*COORD_W +: COORD_W]};
         assign box_hi = {req_ch.box_hi_z_lanes[i*COORD_W +: COORD_W],
                          req_ch.box_hi_y_lanes[i*COORD_W +: COORD_W],
                          req_ch.box_hi_x_lanes[i*COORD_W +: COORD_W]};

         rbst_lane u_lane (
            .clock   (clock),
            .ctrl    (ctrl),
            .origin  (origin),
            .inv_dir (inv_dir),
            .box_lo  (box_lo),
            .box_hi  (box_hi),
            .hit     (lane_hit[i])
         );
      end else begin : g_off
         assign lane_hit[i] = 1'b0;
      end
   end

   rbst_merge u_merge (
      .clock    (clock),
      .ctrl     (ctrl),
      .lane_hit (lane_hit),
      .hit_mask (rsp_ch.hit_mask)
   );

endmodule

@@ rtl/rbst_checker.sv @@
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks for the slab test block, bound to its top level.
// ----------------------------------------------------------------------------
module rbst_checker
   import rbst_pkg::*;
#(
   parameter int LANES = 4
)
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input mask_type rsp_hit_mask
);

   localparam int TESTED = (LANES < PACKED_LANES) ? LANES : PACKED_LANES;
   localparam mask_type LIVE = mask_type'((1 << TESTED) - 1);

   // A stalled result keeps its value until the transfer completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_mask))
      else $error("stalled result changed");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A receiver that takes results never holds back requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

   // Lanes that are not built never report a hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_mask & ~LIVE) == '0)
      else $error("hit reported on a lane that is not built");

   // A request transfer cannot stall while the output stage is empty.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid |-> req_ready)
      else $error("request refused with an empty output");

endmodule

bind ray_box_slab_test_four_lane rbst_checker #(.LANES(LANES)) u_rbst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_hit_mask (rsp_ch.hit_mask)
);
